// ===== rtl/spk_pkg.sv =====
// spk_pkg: shared types, constants and helper functions of the speaker to pcm block
// used by spk_cfg_regs, spk_datapath, one_bit_speaker_to_pcm_core and spk_checker
// no dependencies
package spk_pkg;

  // field widths
  localparam int unsigned VolW    = 10;
  localparam int unsigned RateW   = 18;
  localparam int unsigned ClkW    = 27;
  localparam int unsigned MulW    = 8;
  localparam int unsigned PcmW    = 16;
  localparam int unsigned RemW    = 32;
  localparam int unsigned IdleW   = 30;  // holds five times the widest input clock plus a step
  localparam int unsigned TicksW  = MulW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = ClkW;

  // mid-scale and volume scaling
  localparam logic [PcmW-1:0] MidScale  = 16'h8000;
  localparam logic [PcmW-1:0] SwingMax  = 16'd32767;
  localparam logic [VolW-1:0] VolMax    = 10'd1000;
  // ceil(32.768 * 2^20): v * 32768 / 1000 as a multiply and shift
  localparam logic [25:0]     SwingRcp  = 26'd34359739;
  localparam int unsigned     SwingSh   = 20;

  // filter and decay coefficients
  localparam logic [23:0] FiltOld   = 24'd250;
  localparam logic [23:0] FiltNew   = 24'd6;
  localparam logic [23:0] DecayMul  = 24'd255;
  localparam logic [23:0] DecayBias = 24'h008000;
  localparam logic [23:0] DecayRnd  = 24'd255;

  // register reset values
  localparam logic [VolW-1:0]  VolumeRst     = 10'd500;
  localparam logic [RateW-1:0] SampleRateRst = 18'd44100;
  localparam logic [ClkW-1:0]  TickRateRst   = 27'd1000000;
  localparam logic [MulW-1:0]  StepDivRst    = 8'd1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VOLUME        = 3'd0,
    CFG_SAMPLE_RATE   = 3'd1,
    CFG_TICK_RATE     = 3'd2,
    CFG_STEP_DIV      = 3'd3,
    CFG_INITIAL_LEVEL = 3'd4
  } cfg_idx_t;

  // settings as seen by the datapath
  typedef struct packed {
    logic [PcmW-1:0]  drive_hi;
    logic [PcmW-1:0]  drive_lo;
    logic [RateW-1:0] sample_rate;
    logic [ClkW-1:0]  tick_rate;
    logic [IdleW-1:0] timeout;
    logic [MulW-1:0]  step_div;
  } cfg_t;

  // swing around mid-scale: min(volume, 1000) * 32768 / 1000, capped at 32767
  function automatic logic [PcmW-1:0] swing_of(input logic [VolW-1:0] vol);
    logic [VolW-1:0] v;
    logic [35:0]     prod;
    logic [15:0]     sw;
    v    = (vol > VolMax) ? VolMax : vol;
    prod = 36'(v) * 36'(SwingRcp);
    sw   = prod[SwingSh +: 16];
    return (sw > SwingMax) ? SwingMax : sw;
  endfunction

  // idle timeout: five times the input clock rate, counted in ticks
  function automatic logic [IdleW-1:0] timeout_of(input logic [ClkW-1:0] clk_rate);
    return (IdleW'(clk_rate) << 2) + IdleW'(clk_rate);
  endfunction

  localparam logic [PcmW-1:0]  SwingRst   = swing_of(VolumeRst);
  localparam logic [IdleW-1:0] TimeoutRst = timeout_of(TickRateRst);

endpackage

// ===== rtl/spk_cfg_regs.sv =====
// spk_cfg_regs: configuration registers with derived drive levels and idle timeout
// depends on spk_pkg
module spk_cfg_regs
  import spk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data,
  output cfg_t               cfg
);

  logic [PcmW-1:0] swing_new;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // swing derived from the write data so the drive levels are ready at once
  assign swing_new = swing_of(cfg_data[VolW-1:0]);

  // register file; writes to the initial level index have no effect, a zero step divider is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_hi    <= MidScale + SwingRst;
      cfg.drive_lo    <= MidScale - SwingRst;
      cfg.sample_rate <= SampleRateRst;
      cfg.tick_rate   <= TickRateRst;
      cfg.timeout     <= TimeoutRst;
      cfg.step_div    <= StepDivRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VOLUME: begin
          cfg.drive_hi <= MidScale + swing_new;
          cfg.drive_lo <= MidScale - swing_new;
        end
        CFG_SAMPLE_RATE: begin
          cfg.sample_rate <= cfg_data[RateW-1:0];
        end
        CFG_TICK_RATE: begin
          cfg.tick_rate <= cfg_data[ClkW-1:0];
          cfg.timeout   <= timeout_of(cfg_data[ClkW-1:0]);
        end
        CFG_STEP_DIV: begin
          if (cfg_data[MulW-1:0] != '0) begin
            cfg.step_div <= cfg_data[MulW-1:0];
          end
        end
        CFG_INITIAL_LEVEL: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/spk_datapath.sv =====
// spk_datapath: input register, per-tick state update and result register
// depends on spk_pkg
module spk_datapath
  import spk_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_level,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PcmW-1:0] out_sample
);

  // input register
  logic in_vld;
  logic in_lvl;

  // tick state
  logic              last_level;
  logic [PcmW-1:0]   drive_value;
  logic              active;
  logic [PcmW-1:0]   filter_value;
  logic [PcmW-1:0]   idle_reference;
  logic [IdleW-1:0]  idle_ticks;
  logic [RemW-1:0]   rate_remainder;
  logic [MulW-1:0]   pending_ticks;

  logic [PcmW-1:0]   drive_value_next;
  logic              active_next;
  logic [PcmW-1:0]   filter_value_next;
  logic [PcmW-1:0]   idle_reference_next;
  logic [IdleW-1:0]  idle_ticks_next;
  logic [RemW-1:0]   rate_remainder_next;
  logic [MulW-1:0]   pending_ticks_next;

  // intermediate values
  logic              advance;
  logic [PcmW-1:0]   drive_a;
  logic [TicksW-1:0] ticks;
  logic              drop;
  logic [PcmW-1:0]   filt0;
  logic [RemW-1:0]   rem0;
  logic [IdleW-1:0]  idle0;
  logic [PcmW-1:0]   ref0;
  logic              same_ref;
  logic [IdleW-1:0]  idle1;
  logic              timed_out;
  logic              step;
  logic [23:0]       filt_sum;
  logic [PcmW-1:0]   filt1;
  logic [RemW-1:0]   rem1;
  logic              emit;
  logic [23:0]       decay_sum;

  // process the held tick when the result register is free or being emptied
  assign advance  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_lvl <= in_level;
    end
  end

  // level change loads the drive, then the tick count for this step
  assign drive_a = (in_lvl != last_level) ? (in_lvl ? cfg.drive_hi : cfg.drive_lo)
                                          : drive_value;
  assign ticks   = TicksW'(pending_ticks) + TicksW'(1);
  assign drop    = !active && (idle_reference == drive_a);

  // turning on clears the filter, idle count and rate remainder
  assign filt0 = active ? filter_value   : '0;
  assign rem0  = active ? rate_remainder : '0;
  assign idle0 = active ? idle_ticks     : '0;
  assign ref0  = active ? idle_reference : drive_a;

  // idle tracking
  assign same_ref  = (ref0 == drive_a);
  assign idle1     = same_ref ? (idle0 + IdleW'(ticks)) : IdleW'(ticks);
  assign timed_out = same_ref && (idle1 > cfg.timeout);

  // filter step and rate accumulator
  assign step      = ticks >= TicksW'(cfg.step_div);
  assign filt_sum  = 24'(filt0) * FiltOld + 24'(drive_a) * FiltNew;
  assign filt1     = filt_sum[23:8];
  assign rem1      = rem0 + RemW'(cfg.sample_rate);
  assign emit      = rem1 >= RemW'(cfg.tick_rate);
  // drive decays toward mid-scale, rounding up below it
  assign decay_sum = 24'(drive_a) * DecayMul + DecayBias
                   + (drive_a[PcmW-1] ? 24'd0 : DecayRnd);

  // next state of one tick
  always_comb begin
    drive_value_next    = drive_a;
    active_next         = active;
    filter_value_next   = filter_value;
    idle_reference_next = idle_reference;
    idle_ticks_next     = idle_ticks;
    rate_remainder_next = rate_remainder;
    pending_ticks_next  = '0;
    if (!drop) begin
      filter_value_next   = filt0;
      rate_remainder_next = rem0;
      idle_reference_next = drive_a;
      idle_ticks_next     = idle1;
      if (timed_out) begin
        active_next = 1'b0;
      end else begin
        active_next = 1'b1;
        if (step) begin
          filter_value_next  = filt1;
          pending_ticks_next = MulW'(ticks - TicksW'(cfg.step_div));
          if (emit) begin
            rate_remainder_next = rem1 - RemW'(cfg.tick_rate);
            drive_value_next    = decay_sum[23:8];
          end else begin
            rate_remainder_next = rem1;
          end
        end else begin
          pending_ticks_next = ticks[MulW-1:0];
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      drive_value    <= '0;
      active         <= 1'b0;
      filter_value   <= '0;
      idle_reference <= '0;
      idle_ticks     <= '0;
      rate_remainder <= '0;
      pending_ticks  <= '0;
    end else if (advance) begin
      last_level     <= in_lvl;
      drive_value    <= drive_value_next;
      active         <= active_next;
      filter_value   <= filter_value_next;
      idle_reference <= idle_reference_next;
      idle_ticks     <= idle_ticks_next;
      rate_remainder <= rate_remainder_next;
      pending_ticks  <= pending_ticks_next;
    end
  end

  // result register, sample is the filter value offset by mid-scale
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && !drop && !timed_out && step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !drop && !timed_out && step && emit) begin
      out_sample <= filt1 ^ MidScale;
    end
  end

endmodule

// ===== rtl/one_bit_speaker_to_pcm_core.sv =====
// one_bit_speaker_to_pcm_core: one-bit speaker stream to signed 16-bit pcm samples
// depends on spk_pkg, spk_cfg_regs and spk_datapath
//
//   channel   direction  payload                          handshake
//   s_axis    in         tdata[0] level                   tvalid / tready
//   m_axis    out        tdata[15:0] sample (signed)      tvalid / tready
//   cfg       in         cfg_index, cfg_data              cfg_valid / cfg_ready
//
// one tick per cycle while m_axis is not stalled; a tick goes through the input
// register and one pass of logic, its sample (if any) into the result register
// at most one sample per tick; cfg_ready is always high
// a stalled sample holds the result register; s_axis_tready drops as soon as
// a tick waits in the input register behind it
// synchronous reset, no clearing pass
module one_bit_speaker_to_pcm_core
  import spk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [0] level, [7:1] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [PcmW-1:0]    m_axis_tdata,   // [15:0] sample
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data
);

  cfg_t cfg;

  // configuration registers
  spk_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // tick processing
  spk_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_level   (s_axis_tdata[0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (m_axis_tdata)
  );

endmodule

// ===== rtl/spk_checker.sv =====
// spk_checker: port-level assertions for the speaker to pcm block
// depends on spk_pkg; bound to one_bit_speaker_to_pcm_core
module spk_checker
  import spk_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [PcmW-1:0] m_axis_tdata
);

  // a stalled sample keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled sample changed");

  // input back-pressure only comes from a stalled output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // reset empties both registers
  a_rst_out: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("sample valid after reset");

  a_rst_in: assert property (@(posedge clk)
    $past(rst) |-> s_axis_tready)
    else $error("input not ready after reset");

endmodule

bind one_bit_speaker_to_pcm_core spk_checker u_spk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
